// ----- hw/rtl/saq_pkg.sv -----
// ----------------------------------------------------------------------------
// saq_pkg
// Shared sizes, status codes, control states and types for the sorted
// alarm queue.
// ----------------------------------------------------------------------------
package saq_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 48;
    localparam int TAG_BITS  = 16;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_FIRED    = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCHED,
        S_FIRE
    } state_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [TAG_BITS-1:0]  tag;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/sorted_alarm_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_alarm_queue
// Up to DEPTH one-shot alarms kept earliest first in a chain of cells.
//
// A request on the s_ channel either schedules an alarm (s_req_type = 0,
// absolute deadline or delay from the last known time) or is a tick
// (s_req_type = 1) carrying the current time. Results leave on the m_
// channel from one output register; m_last marks the final result of
// a request.
// A schedule request forms the deadline in the accept cycle; then, once
// the output register is free, every cell compares against it and the
// chain shifts in one step. A tick is accepted and then takes 1 cycle per
// fired alarm while the receiver does not stall, set by the single pop of
// the chain head; a tick with nothing due gives one result. One request is
// worked on at a time; the next is accepted as soon as the last result of
// the previous one is in the output register.
// Reset empties the queue and sets the known time to 0; no clearing pass.
// When the receiver stalls, the held result blocks further work, and the
// payload stays unchanged until m_ready.
// ----------------------------------------------------------------------------
module sorted_alarm_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [saq_pkg::TIME_BITS-1:0]  s_time_value,
    input  logic                           s_relative,
    input  logic [saq_pkg::TAG_BITS-1:0]   s_alarm_tag,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [saq_pkg::TAG_BITS-1:0]   m_fired_tag,
    output logic                           m_last,
    output logic [saq_pkg::CNT_BITS-1:0]   m_queue_count,
    output logic                           m_armed,
    output logic [saq_pkg::TIME_BITS-1:0]  m_next_deadline
);

    localparam int DEPTH = saq_pkg::DEPTH;
    localparam int TB    = saq_pkg::TIME_BITS;
    localparam int GB    = saq_pkg::TAG_BITS;
    localparam int CB    = saq_pkg::CNT_BITS;

    saq_pkg::state_t state_reg, state_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [TB-1:0]   known_reg, known_next;
    logic [TB-1:0]   when_reg, when_next;
    logic [GB-1:0]   tag_reg, tag_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_status_reg, out_status_next;
    logic [GB-1:0]   out_tag_reg, out_tag_next;
    logic            out_last_reg, out_last_next;
    logic [CB-1:0]   out_count_reg;
    logic            out_armed_reg;
    logic [TB-1:0]   out_dl_reg, out_dl_next;

    saq_pkg::cell_ctrl_t ctrl;
    saq_pkg::entry_t     new_entry;
    saq_pkg::entry_t     cell_entry [DEPTH];
    saq_pkg::entry_t     cell_next  [DEPTH];
    logic                cell_keep  [DEPTH];

    logic          accept;
    logic          slot_free;
    logic          load_out;
    logic [TB:0]   delay_sum;
    logic          head_due;
    logic          second_due;

    assign s_ready   = (state_reg == saq_pkg::S_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !out_valid_reg || m_ready;

    assign new_entry.deadline = when_reg;
    assign new_entry.tag      = tag_reg;

    // saturating delay add
    assign delay_sum = {1'b0, known_reg} + {1'b0, s_time_value};

    always_comb begin
        known_next = known_reg;
        when_next  = when_reg;
        tag_next   = tag_reg;
        if (accept) begin
            if (s_req_type) begin
                known_next = s_time_value;
            end else begin
                tag_next = s_alarm_tag;
                if (s_relative) begin
                    when_next = delay_sum[TB] ? {TB{1'b1}} : delay_sum[TB-1:0];
                end else begin
                    when_next = s_time_value;
                end
            end
        end
    end

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            saq_pkg::entry_t prev_e;
            saq_pkg::entry_t next_e;
            logic            prev_k;
            if (gi == 0) begin : g_head
                assign prev_e = new_entry;
                assign prev_k = 1'b0;
            end else begin : g_body
                assign prev_e = cell_entry[gi-1];
                assign prev_k = cell_keep[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign next_e = cell_entry[gi];
            end else begin : g_mid
                assign next_e = cell_entry[gi+1];
            end
            saq_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CB'(gi)),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .keep       (cell_keep[gi]),
                .entry      (cell_entry[gi]),
                .entry_next (cell_next[gi])
            );
        end
    endgenerate

    assign head_due   = (count_reg != '0) && (cell_entry[0].deadline <= known_reg);
    assign second_due = (count_reg > CB'(1)) && (cell_entry[1].deadline <= known_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            saq_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = s_req_type ? saq_pkg::S_FIRE : saq_pkg::S_SCHED;
                end
            end
            saq_pkg::S_SCHED: begin
                if (slot_free) begin
                    state_next = saq_pkg::S_IDLE;
                end
            end
            saq_pkg::S_FIRE: begin
                if (slot_free && (!head_due || !second_due)) begin
                    state_next = saq_pkg::S_IDLE;
                end
            end
            default: state_next = saq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl            = '0;
        load_out        = 1'b0;
        count_next      = count_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            saq_pkg::S_SCHED: begin
                if (slot_free) begin
                    load_out      = 1'b1;
                    out_last_next = 1'b1;
                    out_tag_next  = '0;
                    if (when_reg <= known_reg) begin
                        out_status_next = saq_pkg::ST_FIRED;
                        out_tag_next    = tag_reg;
                    end else if (count_reg == CB'(DEPTH)) begin
                        out_status_next = saq_pkg::ST_FULL;
                    end else begin
                        ctrl.ins        = 1'b1;
                        count_next      = count_reg + CB'(1);
                        out_status_next = saq_pkg::ST_ACCEPTED;
                    end
                end
            end
            saq_pkg::S_FIRE: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    if (head_due) begin
                        ctrl.pop        = 1'b1;
                        count_next      = count_reg - CB'(1);
                        out_status_next = saq_pkg::ST_FIRED;
                        out_tag_next    = cell_entry[0].tag;
                        out_last_next   = !second_due;
                    end else begin
                        out_status_next = saq_pkg::ST_IDLE;
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign out_dl_next = (count_next != '0) ? cell_next[0].deadline : '0;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= saq_pkg::S_IDLE;
            count_reg     <= '0;
            known_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        when_reg <= when_next;
        tag_reg  <= tag_next;
        if (load_out) begin
            out_status_reg <= out_status_next;
            out_tag_reg    <= out_tag_next;
            out_last_reg   <= out_last_next;
            out_count_reg  <= count_next;
            out_armed_reg  <= (count_next != '0);
            out_dl_reg     <= out_dl_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_status_reg;
    assign m_fired_tag     = out_tag_reg;
    assign m_last          = out_last_reg;
    assign m_queue_count   = out_count_reg;
    assign m_armed         = out_armed_reg;
    assign m_next_deadline = out_dl_reg;

endmodule

// ----- hw/rtl/saq_cell.sv -----
// ----------------------------------------------------------------------------
// saq_cell
// One slot of the sorted chain: keeps its entry, shifts back to make room
// for a new alarm or forward when the head fires.
// ----------------------------------------------------------------------------
module saq_cell (
    input  logic                aclk,
    input  saq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  saq_pkg::entry_t     new_entry,
    input  saq_pkg::entry_t     prev_entry,
    input  logic                prev_keep,
    input  saq_pkg::entry_t     next_entry,
    output logic                keep,
    output saq_pkg::entry_t     entry,
    output saq_pkg::entry_t     entry_next
);

    saq_pkg::entry_t entry_reg;

    // earlier deadline stays in place, equal or later moves back
    assign keep = occupied && (entry_reg.deadline < new_entry.deadline);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (!keep) begin
                entry_next = prev_keep ? new_entry : prev_entry;
            end
        end else if (ctrl.pop) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- hw/rtl/saq_checker.sv -----
// ----------------------------------------------------------------------------
// saq_checker
// Port-level checks on the result channel of the sorted alarm queue.
// ----------------------------------------------------------------------------
module saq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [1:0]                     m_status,
    input logic [saq_pkg::TAG_BITS-1:0]   m_fired_tag,
    input logic                           m_last,
    input logic [saq_pkg::CNT_BITS-1:0]   m_queue_count,
    input logic                           m_armed,
    input logic [saq_pkg::TIME_BITS-1:0]  m_next_deadline
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_fired_tag))
        else $error("result changed while stalled");

    a_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_armed == (m_queue_count != '0)))
        else $error("armed disagrees with count");

    a_idle_dl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_armed |-> (m_next_deadline == '0))
        else $error("deadline shown with empty queue");

    a_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != saq_pkg::ST_FIRED) |-> (m_fired_tag == '0))
        else $error("tag on non-fired result");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == saq_pkg::ST_ACCEPTED) || (m_status == saq_pkg::ST_FULL)
            || (m_status == saq_pkg::ST_IDLE)) |-> m_last)
        else $error("single result without last");

endmodule

bind sorted_alarm_queue saq_checker u_saq_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_fired_tag     (m_fired_tag),
    .m_last          (m_last),
    .m_queue_count   (m_queue_count),
    .m_armed         (m_armed),
    .m_next_deadline (m_next_deadline)
);
